/* hw/rtl/clt_pkg.sv */
package clt_pkg;

  // Line length limit and register reset
  localparam int        MAX_LINE_DEF   = 8192;
  localparam logic [7:0] MAX_TOKENS_RST = 8'd16;

  // Depth of the result queue (power of two, at least two)
  localparam int OQ_DEPTH = 4;

  // Register indexes
  localparam int REG_MAX_TOKENS = 0;

  // Byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Record kinds
  localparam logic REC_TOKEN = 1'b0;
  localparam logic REC_FINAL = 1'b1;

  // Line status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_QUOTE = 3'd1,
    ST_QUOTE_ADJ = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } clt_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  token_index;
    logic [12:0] token_start;
    logic [13:0] token_length;
    logic        token_quoted;
    logic [2:0]  status;
    logic [7:0]  token_count;
    logic        last;
  } clt_out_t;

  // Records produced by one item, first then second
  typedef struct packed {
    logic [1:0] count;
    clt_out_t   first;
    clt_out_t   second;
  } clt_push_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* hw/rtl/clt_regs.sv */
module clt_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  max_tokens
);
  import clt_pkg::*;

  logic wr_en;

  // Only one register: every word address selects it
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Hold the token limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens <= MAX_TOKENS_RST;
    end else if (wr_en) begin
      max_tokens <= pwdata[7:0];
    end
  end

  // Read back the limit; byte lane bits of the address are ignored
  always_comb begin
    prdata = '0;
    if (paddr[1:0] >= 2'd0) begin
      prdata = {24'd0, max_tokens};
    end
  end

endmodule

/* hw/rtl/clt_scan.sv */
module clt_scan #(
  parameter int MAX_LINE = clt_pkg::MAX_LINE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  clt_pkg::clt_in_t   item,
  input  logic [7:0]         max_tokens,
  output clt_pkg::clt_push_t push
);
  import clt_pkg::*;

  localparam int PW = $clog2(MAX_LINE + 1);
  localparam int SW = $clog2(MAX_LINE);

  typedef enum logic [5:0] {
    M_BETWEEN = 6'b000001,
    M_WORD    = 6'b000010,
    M_QUOTED  = 6'b000100,
    M_ESCAPE  = 6'b001000,
    M_AFTER_Q = 6'b010000,
    M_DONE    = 6'b100000
  } mode_t;

  mode_t         mode, mode_next;
  logic          quote_kind, quote_kind_next;
  logic [SW-1:0] tok_start, tok_start_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]    tokens, tokens_next;
  status_t       line_status, line_status_next;

  clt_out_t      tok_rec;
  clt_out_t      fin_rec;
  logic [PW-1:0] tok_len;
  logic          emit;
  logic          fail_req;
  status_t       fail_code;
  status_t       fin_status;
  logic [7:0]    fin_count;
  logic [7:0]    c;
  logic [7:0]    close_q;

  assign c       = item.ch;
  assign close_q = quote_kind ? CH_SQUOTE : CH_DQUOTE;
  assign tok_len = pos - PW'(tok_start);

  // Build the token record for the token now ending
  always_comb begin
    tok_rec              = '0;
    tok_rec.record_kind  = REC_TOKEN;
    tok_rec.token_index  = tokens;
    tok_rec.token_start  = 13'(tok_start);
    tok_rec.token_length = 14'(tok_len);
    tok_rec.token_quoted = (mode == M_AFTER_Q);
  end

  // Advance the scanner by one item
  always_comb begin
    mode_next        = mode;
    quote_kind_next  = quote_kind;
    tok_start_next   = tok_start;
    pos_next         = pos;
    tokens_next      = tokens;
    line_status_next = line_status;
    emit             = 1'b0;
    fail_req         = 1'b0;
    fail_code        = ST_OK;
    fin_status       = line_status;
    fin_count        = tokens;
    fin_rec          = '0;
    push             = '0;

    if (accept && item.end_of_line) begin
      // Close the line: flush an open token, then the status record
      if (max_tokens == 8'd0) begin
        fin_status = ST_OK;
        fin_count  = 8'd0;
      end else begin
        if ((mode == M_WORD) || (mode == M_AFTER_Q)) begin
          emit      = 1'b1;
          fin_count = tokens + 8'd1;
        end
        if (((mode == M_QUOTED) || (mode == M_ESCAPE)) && (line_status == ST_OK)) begin
          fin_status = ST_BAD_QUOTE;
        end
        if (fin_status != ST_OK) begin
          fin_count = 8'd0;
        end
      end
      fin_rec.record_kind = REC_FINAL;
      fin_rec.status      = fin_status;
      fin_rec.token_count = fin_count;
      fin_rec.last        = 1'b1;
      if (emit) begin
        push.count  = 2'd2;
        push.first  = tok_rec;
        push.second = fin_rec;
      end else begin
        push.count = 2'd1;
        push.first = fin_rec;
      end
      mode_next        = M_BETWEEN;
      quote_kind_next  = 1'b0;
      tok_start_next   = '0;
      pos_next         = '0;
      tokens_next      = 8'd0;
      line_status_next = ST_OK;
    end else if (accept) begin
      if (pos >= PW'(MAX_LINE)) begin
        // Line full: flag it unless the token limit is zero, and count nothing more
        if (max_tokens != 8'd0) begin
          fail_req  = 1'b1;
          fail_code = ST_TOO_LONG;
        end
      end else begin
        pos_next = pos + PW'(1);
        if (c == CH_NUL) begin
          // Zero byte ends the text
          if ((mode == M_WORD) || (mode == M_AFTER_Q)) begin
            emit = 1'b1;
          end else if ((mode == M_QUOTED) || (mode == M_ESCAPE)) begin
            fail_req  = 1'b1;
            fail_code = ST_BAD_QUOTE;
          end
          mode_next = M_DONE;
        end else begin
          unique case (mode)
            M_BETWEEN: begin
              if (!is_blank(c)) begin
                if ((c == CH_SEMI) || (c == CH_HASH)) begin
                  mode_next = M_DONE;
                end else if (tokens >= max_tokens) begin
                  if (max_tokens == 8'd0) begin
                    mode_next = M_DONE;
                  end else begin
                    fail_req  = 1'b1;
                    fail_code = ST_TOO_MANY;
                  end
                end else begin
                  tok_start_next = SW'(pos);
                  if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
                    quote_kind_next = (c == CH_SQUOTE);
                    mode_next       = M_QUOTED;
                  end else begin
                    mode_next = M_WORD;
                  end
                end
              end
            end
            M_WORD: begin
              if (is_blank(c)) begin
                emit      = 1'b1;
                mode_next = M_BETWEEN;
              end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
                fail_req  = 1'b1;
                fail_code = ST_QUOTE_ADJ;
              end
            end
            M_QUOTED: begin
              if (c == CH_BSLASH) begin
                mode_next = M_ESCAPE;
              end else if (c == close_q) begin
                mode_next = M_AFTER_Q;
              end
            end
            M_ESCAPE: begin
              mode_next = M_QUOTED;
            end
            M_AFTER_Q: begin
              if (is_blank(c)) begin
                emit      = 1'b1;
                mode_next = M_BETWEEN;
              end else begin
                fail_req  = 1'b1;
                fail_code = ST_QUOTE_ADJ;
              end
            end
            M_DONE: begin
              mode_next = M_DONE;
            end
            default: begin
              mode_next = M_DONE;
            end
          endcase
        end
      end
      if (emit) begin
        push.count  = 2'd1;
        push.first  = tok_rec;
        tokens_next = tokens + 8'd1;
      end
      // First error wins; stop tokenizing
      if (fail_req) begin
        mode_next = M_DONE;
        if (line_status == ST_OK) begin
          line_status_next = fail_code;
        end
      end
    end
  end

  // Hold scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_BETWEEN;
      quote_kind  <= 1'b0;
      tok_start   <= '0;
      pos         <= '0;
      tokens      <= 8'd0;
      line_status <= ST_OK;
    end else begin
      mode        <= mode_next;
      quote_kind  <= quote_kind_next;
      tok_start   <= tok_start_next;
      pos         <= pos_next;
      tokens      <= tokens_next;
      line_status <= line_status_next;
    end
  end

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.end_of_line |=> (pos == '0) && (tokens == 8'd0) && (line_status == ST_OK))
    else $error("line state not cleared after terminator");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.first.record_kind == REC_TOKEN) &&
                             (push.second.record_kind == REC_FINAL) && push.second.last)
    else $error("token and final records out of order");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(MAX_LINE))
    else $error("byte position beyond line limit");

  a_error_no_token: assert property (@(posedge clk) disable iff (rst)
    accept && !item.end_of_line && (line_status != ST_OK) |-> (push.count == 2'd0))
    else $error("token reported after an error");

endmodule

/* hw/rtl/clt_outq.sv */
module clt_outq (
  input  logic               clk,
  input  logic               rst,
  input  clt_pkg::clt_push_t push,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output clt_pkg::clt_out_t  out_item
);
  import clt_pkg::*;

  localparam int AW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  clt_out_t      mem [OQ_DEPTH];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  // Stall input unless room for two records
  assign full      = (count > CW'(OQ_DEPTH - 2));

  // Write up to two records
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= push.second;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CW'(push.count) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (CW'(push.count) + count) <= CW'(OQ_DEPTH))
    else $error("result queue overflow");

  a_full_blocks_push: assert property (@(posedge clk) disable iff (rst)
    full |-> (push.count == 2'd0))
    else $error("records pushed while input stalled");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && (push.count == 2'd0) |=> count == $past(count) - CW'(1))
    else $error("queue count did not drop on pop");

endmodule

/* hw/rtl/command_line_tokenizer.sv */
// Shell-style argument tokenizer. Feed one line a byte per item, then a
// terminator item (end_of_line set). A new item is taken every cycle while
// the result queue has room for two records; the scanner is a small state
// update between the input handshake and a four-entry result queue, which
// sets that rate. A token record (index, start, length, quoted flag) comes
// out once a token's closing whitespace, zero byte or terminator is seen;
// the terminator also gives a final record with the status code and token
// count, so it may yield two records. Whitespace is space and TAB through
// CR; ';' or '#' where a token would begin starts a comment. The token
// limit is the max_tokens register at byte address 0.
module command_line_tokenizer #(
  parameter int MAX_LINE = clt_pkg::MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  clt_pkg::clt_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output clt_pkg::clt_out_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import clt_pkg::*;

  logic      accept;
  logic      full;
  logic [7:0] max_tokens;
  clt_push_t push;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  clt_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_tokens (max_tokens)
  );

  clt_scan #(
    .MAX_LINE (MAX_LINE)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (in_item),
    .max_tokens (max_tokens),
    .push       (push)
  );

  clt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* bench/command_line_tokenizer_test.sv */
module command_line_tokenizer_test;
  import clt_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int SETTLE_GAP  = 12;
  localparam int IDLE_PCT    = 13;
  localparam int SHOW_ERRORS = 10;

  typedef enum logic [2:0] {
    SC_BETWEEN, SC_WORD, SC_QUOTED, SC_ESCAPE, SC_AFTER_QUOTE, SC_DONE
  } scan_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  clt_in_t     in_item;
  logic        out_valid;
  logic        out_stall;
  clt_out_t    out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Tokenizer state as the block should hold it
  scan_t       scan;
  logic        single_quote;
  logic [12:0] token_begin;
  int unsigned line_pos;
  logic [7:0]  tokens_seen;
  status_t     line_error;
  logic [7:0]  token_limit;

  clt_out_t    expected_records[$];
  clt_out_t    oldest_record;
  int          mismatches;
  int          cycle_count;
  bit          steady;

  command_line_tokenizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit blank_byte(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit quote_byte(input logic [7:0] c);
    return c == CH_DQUOTE || c == CH_SQUOTE;
  endfunction

  function automatic string record_text(input clt_out_t r);
    return $sformatf("kind=%0d idx=%0d start=%0d len=%0d quoted=%0d status=%0d count=%0d last=%0d",
                     r.record_kind, r.token_index, r.token_start, r.token_length,
                     r.token_quoted, r.status, r.token_count, r.last);
  endfunction

  // Report the token ending just before the current byte
  function automatic void close_token();
    clt_out_t rec;
    rec = '0;
    rec.record_kind  = REC_TOKEN;
    rec.token_index  = tokens_seen;
    rec.token_start  = token_begin;
    rec.token_length = 14'(line_pos - token_begin);
    rec.token_quoted = (scan == SC_AFTER_QUOTE);
    expected_records.push_back(rec);
    tokens_seen = tokens_seen + 8'd1;
  endfunction

  // Keep the first error of the line and stop tokenizing
  function automatic void raise_error(input status_t code);
    if (line_error == ST_OK)
      line_error = code;
    scan = SC_DONE;
  endfunction

  function automatic void restart_line();
    scan         = SC_BETWEEN;
    single_quote = 1'b0;
    token_begin  = '0;
    line_pos     = 0;
    tokens_seen  = '0;
    line_error   = ST_OK;
  endfunction

  function automatic void predict_records(input clt_in_t it);
    clt_out_t   fin;
    logic [7:0] c;
    c = it.ch;
    if (it.end_of_line) begin
      if (token_limit == 8'd0) begin
        line_error  = ST_OK;
        tokens_seen = '0;
      end else if (scan == SC_WORD || scan == SC_AFTER_QUOTE) begin
        close_token();
      end else if (scan == SC_QUOTED || scan == SC_ESCAPE) begin
        raise_error(ST_BAD_QUOTE);
      end
      fin = '0;
      fin.record_kind = REC_FINAL;
      fin.status      = line_error;
      fin.token_count = (line_error == ST_OK) ? tokens_seen : 8'd0;
      fin.last        = 1'b1;
      expected_records.push_back(fin);
      restart_line();
    end else if (line_pos >= MAX_LINE_DEF) begin
      if (token_limit != 8'd0)
        raise_error(ST_TOO_LONG);
    end else begin
      if (c == CH_NUL) begin
        // zero byte ends the text
        if (scan == SC_WORD || scan == SC_AFTER_QUOTE)
          close_token();
        else if (scan == SC_QUOTED || scan == SC_ESCAPE)
          raise_error(ST_BAD_QUOTE);
        scan = SC_DONE;
      end else begin
        case (scan)
          SC_BETWEEN: begin
            if (blank_byte(c)) begin
            end else if (c == CH_SEMI || c == CH_HASH) begin
              scan = SC_DONE;
            end else if (tokens_seen >= token_limit) begin
              if (token_limit == 8'd0)
                scan = SC_DONE;
              else
                raise_error(ST_TOO_MANY);
            end else begin
              token_begin = line_pos[12:0];
              if (quote_byte(c)) begin
                single_quote = (c == CH_SQUOTE);
                scan = SC_QUOTED;
              end else begin
                scan = SC_WORD;
              end
            end
          end
          SC_WORD: begin
            if (blank_byte(c)) begin
              close_token();
              scan = SC_BETWEEN;
            end else if (quote_byte(c)) begin
              raise_error(ST_QUOTE_ADJ);
            end
          end
          SC_QUOTED: begin
            if (c == CH_BSLASH)
              scan = SC_ESCAPE;
            else if (c == (single_quote ? CH_SQUOTE : CH_DQUOTE))
              scan = SC_AFTER_QUOTE;
          end
          SC_ESCAPE: scan = SC_QUOTED;
          SC_AFTER_QUOTE: begin
            if (blank_byte(c)) begin
              close_token();
              scan = SC_BETWEEN;
            end else begin
              raise_error(ST_QUOTE_ADJ);
            end
          end
          default: scan = SC_DONE;
        endcase
      end
      line_pos = line_pos + 1;
    end
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_ERRORS)
          $display("record with none expected: %s", record_text(out_item));
      end else begin
        oldest_record = expected_records.pop_front();
        if (out_item.record_kind  !== oldest_record.record_kind  ||
            out_item.token_index  !== oldest_record.token_index  ||
            out_item.token_start  !== oldest_record.token_start  ||
            out_item.token_length !== oldest_record.token_length ||
            out_item.token_quoted !== oldest_record.token_quoted ||
            out_item.status       !== oldest_record.status       ||
            out_item.token_count  !== oldest_record.token_count  ||
            out_item.last         !== oldest_record.last) begin
          mismatches++;
          if (mismatches <= SHOW_ERRORS) begin
            $display("record mismatch");
            $display("  expected %s", record_text(oldest_record));
            $display("  actual   %s", record_text(out_item));
          end
        end
      end
    end
  end

  // Receiver stalls at random unless a steady stretch is running
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic send_item(input logic [7:0] c, input logic eol);
    clt_in_t it;
    it.ch          = c;
    it.end_of_line = eol;
    // idle the sender at random
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predict_records(it);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0);
  endtask

  task automatic end_line();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Hold off until every expected record is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_records.size() != 0)
      @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic write_token_limit(input logic [7:0] limit);
    logic [31:0] word;
    word = $urandom;
    word[7:0] = limit;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 2'(REG_MAX_TOKENS * 4);
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    token_limit = limit;
    // read back
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== limit) begin
      mismatches++;
      if (mismatches <= SHOW_ERRORS)
        $display("max_tokens readback: expected %0d actual %0d", limit, prdata[7:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // -------------------------------------------------------------------- tests

  // Quotes of both kinds, escape, bad quote, adjoining quote, zero byte, comment
  task automatic test_directed();
    send_text("a\t'b\\'c' \"d\"");
    end_line();
    send_text("x\"");
    end_line();
    send_text("'q");
    end_line();
    send_item(8'hFF, 1'b0);
    send_item(CH_NUL, 1'b0);
    send_item(8'h7A, 1'b0);
    end_line();
    send_text(";#");
    end_line();
    end_line();
  endtask

  task automatic test_token_limit();
    settle();
    write_token_limit(8'd2);
    send_text("a b c");
    end_line();
    send_text("a 'b' #c");
    end_line();
    send_text("a b \v\f\015\n");
    end_line();
    // lower the limit in the middle of a line
    send_text("a b ");
    settle();
    write_token_limit(8'd1);
    send_text("c");
    end_line();
    settle();
    write_token_limit(8'd0);
    send_text("a 'b");
    end_line();
    send_text("x\"y");
    end_line();
  endtask

  function automatic logic [7:0] pick_blank();
    int b;
    b = $urandom_range(0, 5);
    return (b == 5) ? CH_SPACE : CH_TAB + 8'(b);
  endfunction

  function automatic logic [7:0] pick_word_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 255)); while (quote_byte(c));
    return c;
  endfunction

  // Well-formed token lines with random content, some broken by noise
  task automatic random_lines(input int budget);
    logic [7:0] line[$];
    logic [7:0] q;
    logic [7:0] c;
    int         sent;
    int         n_tok;
    sent = 0;
    while (sent < budget) begin
      line = {};
      n_tok = $urandom_range(0, 6);
      for (int t = 0; t < n_tok; t++) begin
        repeat ($urandom_range(t == 0 ? 0 : 1, 3)) line.push_back(pick_blank());
        if ($urandom_range(99) < 60) begin
          repeat ($urandom_range(1, 6)) line.push_back(pick_word_byte());
        end else begin
          q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
          line.push_back(q);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(99) < 15) begin
              line.push_back(CH_BSLASH);
              line.push_back(8'($urandom_range(1, 255)));
            end else begin
              do c = 8'($urandom_range(1, 255)); while (c == q || c == CH_BSLASH);
              line.push_back(c);
            end
          end
          line.push_back(q);
        end
      end
      if ($urandom_range(99) < 40)
        repeat ($urandom_range(1, 2)) line.push_back(pick_blank());
      if ($urandom_range(99) < 10) begin
        line.push_back($urandom_range(1) ? CH_SEMI : CH_HASH);
        repeat ($urandom_range(0, 4)) line.push_back(8'($urandom_range(255)));
      end
      // break the line now and then
      if (line.size() != 0 && $urandom_range(99) < 20)
        line[$urandom_range(line.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(99) < 8)
        line.insert($urandom_range(line.size()), 8'($urandom_range(255)));
      foreach (line[i])
        send_item(line[i], 1'b0);
      end_line();
      sent += line.size() + 1;
    end
  endtask

  task automatic test_random();
    logic [7:0] limits[5];
    limits = '{8'd16, 8'd0, 8'd255, 8'd1, 8'd3};
    limits[0] = 8'($urandom_range(2, 254));
    foreach (limits[p]) begin
      settle();
      write_token_limit(limits[p]);
      steady = (p == 2);
      random_lines(165);
      steady = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    mismatches  = 0;
    cycle_count = 0;
    steady      = 1'b0;
    token_limit = MAX_TOKENS_RST;
    restart_line();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_token_limit();
    test_random();

    settle();
    repeat (20) @(negedge clk);
    if (expected_records.size() != 0) begin
      mismatches++;
      if (mismatches <= SHOW_ERRORS)
        $display("%0d expected records never arrived", expected_records.size());
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
